// ===== rtl/sha224_pkg.sv =====
// Shared types, constants and round functions for the SHA-224 hash engine.
// Used by sha224_ctrl, sha224_dp and sha224_hash_engine; depends on nothing.
package sha224_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned STATE_WORDS  = 8;
    localparam int unsigned ROUNDS       = 64;
    localparam int unsigned DIGEST_WORDS = 7;

    localparam logic [3:0] LAST_BLOCK_SLOT = 4'(BLOCK_WORDS - 1);
    localparam logic [5:0] LAST_ROUND      = 6'(ROUNDS - 1);
    localparam logic [2:0] LAST_DIGEST_IDX = 3'(DIGEST_WORDS - 1);

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [31:0] message_word;
        logic        message_end;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } digest_item_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_word;
        logic       start_block;
        logic       do_round;
        logic       finalize;
        logic       reinit;
        logic [5:0] round;
        logic [2:0] sel;
    } dp_cmd_t;

    localparam word_t K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t IV_TABLE [STATE_WORDS] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/sha224_ctrl.sv =====
// Sequencer for the SHA-224 engine: word collection, round count, digest readout.
// Depends on sha224_pkg; drives sha224_dp through a dp_cmd_t command bundle.
module sha224_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    input  logic                 message_end,
    output logic                 msg_stall,
    output logic                 digest_valid,
    input  logic                 digest_stall,
    output sha224_pkg::dp_cmd_t  cmd
);
    import sha224_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [3:0]  word_count_reg, word_count_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        end_reg, end_next;
    logic        word_take;
    logic        digest_take;

    assign word_take   = (state_reg == ST_COLLECT) && msg_valid;
    assign digest_take = (state_reg == ST_EMIT) && !digest_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            word_count_reg <= '0;
            round_reg      <= '0;
            idx_reg        <= '0;
            end_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            round_reg      <= round_next;
            idx_reg        <= idx_next;
            end_reg        <= end_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next      = state_reg;
        word_count_next = word_count_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (word_take)
                begin
                    word_count_next = word_count_reg + 4'd1;
                    if (word_count_reg == LAST_BLOCK_SLOT)
                    begin
                        // end mark only counts on the word that completes a block
                        end_next   = message_end;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                idx_next = '0;
                if (end_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_COLLECT;
                end
            end
            ST_EMIT:
            begin
                if (digest_take)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_DIGEST_IDX)
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        msg_stall       = (state_reg != ST_COLLECT);
        digest_valid    = (state_reg == ST_EMIT);
        cmd.load_word   = word_take;
        cmd.start_block = word_take && (word_count_reg == LAST_BLOCK_SLOT);
        cmd.do_round    = (state_reg == ST_ROUND);
        cmd.finalize    = (state_reg == ST_FINAL);
        cmd.reinit      = digest_take && (idx_reg == LAST_DIGEST_IDX);
        cmd.round       = round_reg;
        cmd.sel         = idx_reg;
    end

endmodule

// ===== rtl/sha224_dp.sv =====
// Datapath for the SHA-224 engine: schedule window, working variables, chaining state.
// Depends on sha224_pkg; commanded by sha224_ctrl.
module sha224_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha224_pkg::dp_cmd_t      cmd,
    input  logic [31:0]              message_word,
    output sha224_pkg::digest_item_t digest
);
    import sha224_pkg::*;

    // w_reg holds W[t..t+15]; wv_reg holds a..h
    word_t w_reg     [BLOCK_WORDS];
    word_t w_next    [BLOCK_WORDS];
    word_t wv_reg    [STATE_WORDS];
    word_t wv_next   [STATE_WORDS];
    word_t chain_reg [STATE_WORDS];
    word_t chain_next[STATE_WORDS];

    word_t sched_new;
    word_t t1;
    word_t t2;
    word_t choose;
    word_t major;

    always_comb
    begin
        sched_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
        choose    = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        major     = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                    ^ (wv_reg[1] & wv_reg[2]);
        t1        = wv_reg[7] + big_sigma1(wv_reg[4]) + choose + K_TABLE[cmd.round] + w_reg[0];
        t2        = big_sigma0(wv_reg[0]) + major;
    end

    always_comb
    begin
        w_next  = w_reg;
        wv_next = wv_reg;
        // advance the window on each new word and each round
        if (cmd.load_word || cmd.do_round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[BLOCK_WORDS-1] = cmd.load_word ? message_word : sched_new;
        end
        if (cmd.start_block)
        begin
            wv_next = chain_reg;
        end
        else if (cmd.do_round)
        begin
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.finalize)
        begin
            for (int i = 0; i < STATE_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + wv_reg[i];
            end
        end
        else if (cmd.reinit)
        begin
            chain_next = IV_TABLE;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg  <= w_next;
        wv_reg <= wv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= IV_TABLE;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_comb
    begin
        digest.digest_word = chain_reg[cmd.sel];
        digest.word_index  = cmd.sel;
        digest.digest_last = (cmd.sel == LAST_DIGEST_IDX);
    end

endmodule

// ===== rtl/sha224_hash_engine.sv =====
// SHA-224 hash engine top level: controller plus datapath.
// Depends on sha224_pkg, sha224_ctrl and sha224_dp.
//
// Feed the padded message as 32-bit big-endian words, one transaction per
// word; message_end counts only on the sixteenth word of a block. The 16
// words of a block are taken one per cycle, then the single round unit runs
// the 64 compression rounds at one round per cycle and a final step adds
// the result into the chaining state, with msg_stall high through the
// rounds and the final step. After the final block the seven digest words
// H0..H6 leave in order, one per cycle unless digest_stall holds them, the
// last one marked by digest_last; the chaining state then returns to the
// SHA-224 initial value and the next message may start.
module sha224_hash_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    input  sha224_pkg::msg_item_t    msg,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output sha224_pkg::digest_item_t digest
);
    import sha224_pkg::*;

    dp_cmd_t cmd;

    sha224_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .message_end  (msg.message_end),
        .msg_stall    (msg_stall),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .cmd          (cmd)
    );

    sha224_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (msg.message_word),
        .digest       (digest)
    );

    // No message word is taken while a digest is being read out
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> msg_stall)
        else $error("message transaction possible during digest readout");

    // Digest words leave in consecutive order
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && !digest.digest_last)
        |=> (digest_valid && (digest.word_index == $past(digest.word_index) + 3'd1)))
        else $error("digest word order broken");

    // Readout ends right after the last digest word
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && digest.digest_last) |=> !digest_valid)
        else $error("digest readout continued past last word");

    // Readout starts at word zero
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (digest.word_index == 3'd0))
        else $error("digest readout did not start at word zero");

endmodule

// ===== dv/sha224_digest_check_pkg.sv =====
`timescale 1ns / 100ps
// SHA-224 digest predictor and scoreboard for the hash engine testbench.
// Depends on sha224_pkg for the transaction types and the block and digest index constants.
package sha224_digest_check_pkg;

    import sha224_pkg::*;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    class sha224_digest_scoreboard;

        logic [31:0]  chain [8];
        logic [31:0]  block [16];
        int unsigned  fill;
        int unsigned  digests_done;
        int unsigned  errors;
        digest_item_t expected_q [$];

        function new();
            foreach (chain[i])
            begin
                chain[i] = INIT_HASH[i];
            end
            fill = 0;
            digests_done = 0;
            errors = 0;
        endfunction

        function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] sched [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++)
            begin
                sched[i] = block[i];
            end
            for (int i = 16; i < 64; i++)
            begin
                s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
                s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
                sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
            end
            foreach (v[i])
            begin
                v[i] = chain[i];
            end
            for (int r = 0; r < 64; r++)
            begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched[r];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (chain[i])
            begin
                chain[i] = chain[i] + v[i];
            end
        endfunction

        // Note one accepted message word; queue the digest if it ends a message.
        function void note_word(input msg_item_t item);
            digest_item_t d;
            block[fill] = item.message_word;
            if (fill != LAST_BLOCK_SLOT)
            begin
                fill++;
                return;
            end
            fill = 0;
            compress();
            // the end mark counts only on the word that completes a block
            if (!item.message_end)
                return;
            for (int i = 0; i <= LAST_DIGEST_IDX; i++)
            begin
                d.digest_word = chain[i];
                d.word_index  = 3'(i);
                d.digest_last = (i == LAST_DIGEST_IDX);
                expected_q.push_back(d);
            end
            foreach (chain[i])
            begin
                chain[i] = INIT_HASH[i];
            end
            digests_done++;
        endfunction

        function void check_digest(input digest_item_t got);
            digest_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected digest transaction: expected none, got %h/%0d/%0b",
                         $time, got.digest_word, got.word_index, got.digest_last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $display("%0t: digest_word mismatch: expected %h, got %h",
                         $time, want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $display("%0t: word_index mismatch: expected %0d, got %0d",
                         $time, want.word_index, got.word_index);
                errors++;
            end
            if (got.digest_last !== want.digest_last)
            begin
                $display("%0t: digest_last mismatch: expected %0b, got %0b",
                         $time, want.digest_last, got.digest_last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

// ===== dv/sha224_hash_engine_test.sv =====
`timescale 1ns / 100ps
// Top-level testbench for sha224_hash_engine: drives message words, stalls the
// digest side and checks every digest word. Depends on sha224_pkg and
// sha224_digest_check_pkg.
module sha224_hash_engine_test;

    import sha224_pkg::*;
    import sha224_digest_check_pkg::*;

    localparam int unsigned TOTAL_WORDS    = 236;
    localparam int unsigned CALM_AFTER     = 190;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 100;

    logic         clk;
    logic         rst_n;
    logic         msg_valid;
    logic         msg_stall;
    msg_item_t    msg;
    logic         digest_valid;
    logic         digest_stall;
    digest_item_t digest;

    sha224_digest_scoreboard sb;
    bit          calm;
    int unsigned words_sent;

    sha224_hash_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one word and hold it until the engine takes it.
    task automatic send_word(input logic [31:0] word, input logic end_mark);
        msg_item_t item;
        item.message_word = word;
        item.message_end  = end_mark;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= item;
        do @(posedge clk); while (msg_stall);
        sb.note_word(item);
        words_sent++;
    endtask

    // Hold the sender until every queued digest word has come out.
    task automatic hold_until_drained();
        msg_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Well-formed message; noisy ones carry stray end marks inside blocks.
    task automatic send_message(input int unsigned blocks, input bit noisy);
        for (int b = 0; b < blocks; b++)
        begin
            for (int s = 0; s <= LAST_BLOCK_SLOT; s++)
            begin
                if (s == LAST_BLOCK_SLOT)
                    send_word($urandom, b == blocks - 1);
                else
                    send_word($urandom, noisy && $urandom_range(0, 2) == 0);
            end
        end
    endtask

    // Misaligned junk, then complete the open block without an end mark.
    task automatic send_noise();
        repeat ($urandom_range(1, 20)) send_word($urandom, $urandom_range(0, 1));
        while (sb.fill != 0)
        begin
            if (sb.fill == LAST_BLOCK_SLOT)
                send_word($urandom, 1'b0);
            else
                send_word($urandom, $urandom_range(0, 1));
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] edge_words [8];
        int unsigned pick;
        int unsigned msg_count;
        sb = new();
        calm = 1'b0;
        words_sent = 0;
        msg_count = 0;
        edge_words = '{32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
                       32'h7fffffff, 32'hfffffffe, 32'haaaaaaaa, 32'h55555555};
        rst_n     <= 1'b0;
        msg_valid <= 1'b0;
        msg       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-block message: extreme words, stray end marks, honored end mark
        for (int s = 0; s <= LAST_BLOCK_SLOT; s++)
        begin
            if (s < 8)
                send_word(edge_words[s], s == 0 || s == 2 || s == 5);
            else
                send_word($urandom, s == 9 || s == LAST_BLOCK_SLOT);
        end
        hold_until_drained();

        while (words_sent < TOTAL_WORDS || sb.digests_done < 6)
        begin
            if (words_sent >= CALM_AFTER)
                calm = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick == 0 && !calm)
                send_noise();
            else
                send_message($urandom_range(0, 4) == 0 ? 3 : $urandom_range(1, 2),
                             pick < 3);
            msg_count++;
            if (msg_count == 4)
                hold_until_drained();
        end

        msg_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : digest_side
        int unsigned stall_left;
        stall_left = 0;
        digest_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && digest_valid && !digest_stall)
                sb.check_digest(digest);
            if (calm || !rst_n)
                stall_left = 0;
            else if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            digest_stall <= (stall_left != 0);
        end
    end

    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        do
        begin
            @(posedge clk);
            if (!rst_n || (msg_valid && !msg_stall) || (digest_valid && !digest_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        while (idle_cycles < WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sha224_pkg.sv
rtl/sha224_ctrl.sv
rtl/sha224_dp.sv
rtl/sha224_hash_engine.sv
dv/sha224_digest_check_pkg.sv
dv/sha224_hash_engine_test.sv
